// ----- src/tsc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the text sample classifier: shared types, character codes and
// report codes. No dependencies.
package tsc_pkg;

    localparam int TSC_SAMPLE_BYTES = 512;

    // field widths fixed by the stream format
    localparam int BYTE_W    = 8;
    localparam int CHAR_W    = 7;
    localparam int REPORT_W  = 10;
    localparam int OUT_DATA_W = 32;

    // 7-bit character codes
    localparam logic [CHAR_W-1:0] CH_TAB   = 7'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 7'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 7'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
    localparam logic [CHAR_W-1:0] CH_DEL   = 7'd127;

    // UTF-8 byte bounds
    localparam logic [BYTE_W-1:0] U8_CONT_LO = 8'h80;
    localparam logic [BYTE_W-1:0] U8_CONT_HI = 8'hBF;
    localparam logic [BYTE_W-1:0] U8_LEAD_LO = 8'hC2;
    localparam logic [BYTE_W-1:0] U8_LEAD3   = 8'hE0;
    localparam logic [BYTE_W-1:0] U8_LEAD_ED = 8'hED;
    localparam logic [BYTE_W-1:0] U8_LEAD4   = 8'hF0;
    localparam logic [BYTE_W-1:0] U8_LEAD_HI = 8'hF4;
    localparam logic [BYTE_W-1:0] U8_BOUND_A0 = 8'hA0;
    localparam logic [BYTE_W-1:0] U8_BOUND_90 = 8'h90;

    // line-end flag bits
    localparam int LE_LONE_CR = 0;
    localparam int LE_LONE_LF = 1;
    localparam int LE_CRLF    = 2;

    // high-bit report codes
    localparam logic [1:0] HB_CLEAR = 2'd0;
    localparam logic [1:0] HB_SET   = 2'd1;
    localparam logic [1:0] HB_MIXED = 2'd2;
    localparam logic [1:0] HB_UTF8  = 2'd3;

    // bound on the byte after a lead byte
    typedef enum logic [2:0] {
        RULE_NONE,
        RULE_E0,   // needs >= A0
        RULE_ED,   // needs <  A0
        RULE_F0,   // needs >= 90
        RULE_F4    // needs <  90
    } t_rule;

    typedef struct packed {
        logic [1:0] left;
        t_rule      rule;
        logic       multibyte;
        logic       invalid;
    } t_utf_state;

    typedef struct packed {
        logic       cr_pending;
        logic [2:0] end_flags;
        logic       tab_seen;
        logic       binary_seen;
    } t_stats;

endpackage

// ----- src/tsc_utf8_check.sv -----
`timescale 1ns / 1ps
// Strict UTF-8 checker: running sequence state, one byte per step.
// Depends on tsc_pkg.
module tsc_utf8_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic               i_clear,
    input  logic [7:0]         i_byte,
    output tsc_pkg::t_utf_state o_next
);
    import tsc_pkg::*;

    t_utf_state r_st;
    t_utf_state n_st;
    logic       rule_bad;

    always_comb begin
        unique case (r_st.rule)
            RULE_E0: rule_bad = (i_byte < U8_BOUND_A0);
            RULE_ED: rule_bad = (i_byte >= U8_BOUND_A0);
            RULE_F0: rule_bad = (i_byte < U8_BOUND_90);
            RULE_F4: rule_bad = (i_byte >= U8_BOUND_90);
            default: rule_bad = 1'b0;
        endcase
    end

    always_comb begin
        n_st = r_st;
        if (i_take && !r_st.invalid) begin
            if (r_st.left == 2'd0) begin
                if (i_byte >= U8_CONT_LO) begin
                    if (i_byte < U8_LEAD_LO || i_byte > U8_LEAD_HI) begin
                        n_st.invalid = 1'b1;
                    end else begin
                        n_st.left = (i_byte < U8_LEAD3) ? 2'd1 :
                                    (i_byte < U8_LEAD4) ? 2'd2 : 2'd3;
                        n_st.rule = (i_byte == U8_LEAD3)   ? RULE_E0 :
                                    (i_byte == U8_LEAD_ED) ? RULE_ED :
                                    (i_byte == U8_LEAD4)   ? RULE_F0 :
                                    (i_byte == U8_LEAD_HI) ? RULE_F4 : RULE_NONE;
                        n_st.multibyte = 1'b1;
                    end
                end
            end else if (i_byte < U8_CONT_LO || i_byte > U8_CONT_HI || rule_bad) begin
                n_st.invalid = 1'b1;
            end else begin
                n_st.rule = RULE_NONE;
                n_st.left = r_st.left - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_st <= '{left: 2'd0, rule: RULE_NONE, multibyte: 1'b0, invalid: 1'b0};
        end else begin
            r_st <= n_st;
        end
    end

    assign o_next = n_st;

endmodule

// ----- src/tsc_text_stats.sv -----
`timescale 1ns / 1ps
// One set of text statistics: line endings, line count, tab and control bytes.
// Depends on tsc_pkg.
module tsc_text_stats #(
    parameter int CNT_W = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic                  i_clear,
    input  logic                  i_skip,   // high byte: only ends a pending CR
    input  logic [6:0]            i_char,
    output tsc_pkg::t_stats       o_next,
    output logic [CNT_W-1:0]      o_next_lines
);
    import tsc_pkg::*;

    t_stats           r_st;
    t_stats           n_st;
    logic [CNT_W-1:0] r_lines;
    logic [CNT_W-1:0] n_lines;

    always_comb begin
        n_st    = r_st;
        n_lines = r_lines;
        if (i_take) begin
            if (i_skip) begin
                if (r_st.cr_pending) begin
                    n_st.end_flags[LE_LONE_CR] = 1'b1;
                    n_st.cr_pending = 1'b0;
                end
            end else if (i_char == CH_CR) begin
                n_lines = r_lines + 1'b1;
                n_st.cr_pending = 1'b1;
            end else if (i_char == CH_LF) begin
                if (r_st.cr_pending) begin
                    n_st.end_flags[LE_CRLF] = 1'b1;
                end else begin
                    n_st.end_flags[LE_LONE_LF] = 1'b1;
                    n_lines = r_lines + 1'b1;
                end
                n_st.cr_pending = 1'b0;
            end else begin
                if (r_st.cr_pending) begin
                    n_st.end_flags[LE_LONE_CR] = 1'b1;
                    n_st.cr_pending = 1'b0;
                end
                if (i_char == CH_TAB) begin
                    n_st.tab_seen = 1'b1;
                end else if (i_char < CH_SPACE || i_char == CH_DEL) begin
                    n_st.binary_seen = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_st    <= '0;
            r_lines <= '0;
        end else begin
            r_st    <= n_st;
            r_lines <= n_lines;
        end
    end

    assign o_next       = n_st;
    assign o_next_lines = n_lines;

endmodule

// ----- src/text_sample_classifier.sv -----
`timescale 1ns / 1ps
// Text sample classifier: takes a file sample one byte per request on the
// slave stream (tlast on the final byte, tuser = file continues beyond the
// sample) and on the final byte returns one report on the master stream:
// text or binary, strict UTF-8 verdict, line endings, high-bit mix, line
// count, length and tab flag. Throughput is one byte per clock; a byte is
// registered on entry and then folded into the running state, and the report
// is written to an output register as its final byte is folded in, and is
// held there on the master stream while the next sample streams in. Only a
// final byte can stall the input, and only while the previous report has not
// been taken. Bytes beyond SAMPLE_BYTES are dropped; the length saturates
// there. Depends on tsc_pkg, tsc_utf8_check and tsc_text_stats.
module text_sample_classifier #(
    parameter int SAMPLE_BYTES = tsc_pkg::TSC_SAMPLE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last
    input  logic        s_axis_tuser,   // file_continues
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] is_text, [1] is_utf8, [4:2] line_end_kind, [6:5] high_bit_kind,
    // [16:7] line_count, [26:17] sample_length, [27] has_tab, [31:28] zero
    output logic [31:0] m_axis_tdata
);
    import tsc_pkg::*;

    localparam int CNT_W = $clog2(SAMPLE_BYTES + 1);
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(SAMPLE_BYTES);

    // entry register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             r_in_cont;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_high_seen;
    logic             r_low_seen;
    logic             n_high_seen;
    logic             n_low_seen;

    logic             r_out_valid;
    logic [31:0]      r_out_data;

    logic             advance;
    logic             take;
    logic             finish;

    t_utf_state       utf_next;
    t_stats           u_next;
    t_stats           r_next;
    logic [CNT_W-1:0] u_lines;
    logic [CNT_W-1:0] r_lines;

    logic             utf;
    t_stats           sel;
    logic [CNT_W-1:0] sel_lines;
    logic [2:0]       ends;
    logic [1:0]       hb;
    logic [CNT_W+REPORT_W-1:0] lines_ext;
    logic [CNT_W+REPORT_W-1:0] count_ext;
    logic [31:0]      report;

    // a final byte may only proceed when the output register can take its report
    assign advance = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign take    = advance && (r_count < LIMIT);
    assign finish  = advance && r_in_last;

    assign n_count     = take ? r_count + 1'b1 : r_count;
    assign n_high_seen = r_high_seen || (take && r_in_byte[7]);
    assign n_low_seen  = r_low_seen  || (take && !r_in_byte[7]);

    tsc_utf8_check u_utf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_clear (finish),
        .i_byte  (r_in_byte),
        .o_next  (utf_next)
    );

    tsc_text_stats #(.CNT_W(CNT_W)) u_stats_utf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_clear      (finish),
        .i_skip       (r_in_byte[7]),
        .i_char       (r_in_byte[6:0]),
        .o_next       (u_next),
        .o_next_lines (u_lines)
    );

    tsc_text_stats #(.CNT_W(CNT_W)) u_stats_raw (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_clear      (finish),
        .i_skip       (1'b0),
        .i_char       (r_in_byte[6:0]),
        .o_next       (r_next),
        .o_next_lines (r_lines)
    );

    // verdict: a cut sequence passes only in a full sample of a longer file
    always_comb begin
        if (utf_next.invalid) begin
            utf = 1'b0;
        end else if (utf_next.left != 2'd0) begin
            utf = (n_count == LIMIT) && r_in_cont;
        end else begin
            utf = utf_next.multibyte;
        end
    end

    assign sel       = utf ? u_next : r_next;
    assign sel_lines = utf ? u_lines : r_lines;
    assign ends      = sel.end_flags | {2'b00, sel.cr_pending};

    always_comb begin
        priority if (utf) begin
            hb = HB_UTF8;
        end else if (n_high_seen) begin
            hb = n_low_seen ? HB_MIXED : HB_SET;
        end else begin
            hb = HB_CLEAR;
        end
    end

    assign lines_ext = {{REPORT_W{1'b0}}, sel_lines};
    assign count_ext = {{REPORT_W{1'b0}}, n_count};

    always_comb begin
        report = '0;
        report[1]     = utf;
        report[26:17] = count_ext[REPORT_W-1:0];
        if (!sel.binary_seen) begin
            report[0]     = 1'b1;
            report[4:2]   = ends;
            report[6:5]   = hb;
            report[16:7]  = lines_ext[REPORT_W-1:0];
            report[27]    = sel.tab_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
            r_in_cont <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || finish) begin
            r_count     <= '0;
            r_high_seen <= 1'b0;
            r_low_seen  <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_high_seen <= n_high_seen;
            r_low_seen  <= n_low_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_data <= report;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for text_sample_classifier: streams file samples in,
// predicts each report in step with accepted bytes and checks it field by field.
// Depends on tsc_pkg and the text_sample_classifier RTL.
module testbench;
    import tsc_pkg::*;

    localparam int SAMPLE_MAX   = TSC_SAMPLE_BYTES;
    localparam int RANDOM_BYTES = 560;
    localparam int FULL_SAMPLES = 2;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       cont;
    } stream_byte_t;

    typedef struct packed {
        logic       cr_pending;
        logic [2:0] end_flags;
        logic [9:0] lines;
        logic       tab_seen;
        logic       binary_seen;
    } tally_t;

    typedef struct packed {
        logic       is_text;
        logic       is_utf8;
        logic [2:0] line_ends;
        logic [1:0] high_bits;
        logic [9:0] lines;
        logic [9:0] length;
        logic       has_tab;
    } report_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0; // last
    logic        s_axis_tuser = 1'b0; // file_continues
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] is_text, [1] is_utf8, [4:2] line_end_kind, [6:5] high_bit_kind,
    // [16:7] line_count, [26:17] sample_length, [27] has_tab, [31:28] zero
    logic [31:0] m_axis_tdata;

    text_sample_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- predictor state ----------------
    logic [1:0] seq_left;
    t_rule      seq_rule;
    logic       multibyte, utf_bad;
    logic [9:0] taken;
    tally_t     u_tally, r_tally;
    logic       high_seen, low_seen, overran;

    report_t      expected_reports[$];
    stream_byte_t byte_feed[$];
    logic [7:0]   sample_buf[$];

    int mismatches      = 0;
    int bytes_accepted  = 0;
    int total_bytes     = 0;
    int reports_seen    = 0;
    int samples_done    = 0;
    int utf_samples     = 0;
    int binary_samples  = 0;
    int overrun_samples = 0;

    task clear_sample_state;
        seq_left  = '0;
        seq_rule  = RULE_NONE;
        multibyte = 1'b0;
        utf_bad   = 1'b0;
        taken     = '0;
        u_tally   = '0;
        r_tally   = '0;
        high_seen = 1'b0;
        low_seen  = 1'b0;
        overran   = 1'b0;
    endtask

    function automatic tally_t tally_char(tally_t t, logic [6:0] k);
        tally_t n;
        n = t;
        if (k == CH_CR) begin
            n.lines      = n.lines + 1'b1;
            n.cr_pending = 1'b1;
        end else if (k == CH_LF) begin
            if (n.cr_pending) begin
                n.end_flags[LE_CRLF] = 1'b1;
            end else begin
                n.end_flags[LE_LONE_LF] = 1'b1;
                n.lines = n.lines + 1'b1;
            end
            n.cr_pending = 1'b0;
        end else begin
            if (n.cr_pending) begin
                n.end_flags[LE_LONE_CR] = 1'b1;
                n.cr_pending = 1'b0;
            end
            if (k == CH_TAB)
                n.tab_seen = 1'b1;
            else if (k < CH_SPACE || k == CH_DEL)
                n.binary_seen = 1'b1;
        end
        return n;
    endfunction

    // Folds one accepted byte into the running state; on the final byte
    // queues the report the block should give.
    task classify_byte(input logic [7:0] c, input logic last, input logic cont);
        report_t rep;
        tally_t  s;
        logic    utf;
        if (taken < SAMPLE_MAX) begin
            taken = taken + 1'b1;
            if (!utf_bad) begin
                if (seq_left == 2'd0) begin
                    if (c >= U8_CONT_LO) begin
                        if (c < U8_LEAD_LO || c > U8_LEAD_HI) begin
                            utf_bad = 1'b1;
                        end else begin
                            seq_left  = (c < U8_LEAD3) ? 2'd1 : (c < U8_LEAD4) ? 2'd2 : 2'd3;
                            seq_rule  = (c == U8_LEAD3)   ? RULE_E0 :
                                        (c == U8_LEAD_ED) ? RULE_ED :
                                        (c == U8_LEAD4)   ? RULE_F0 :
                                        (c == U8_LEAD_HI) ? RULE_F4 : RULE_NONE;
                            multibyte = 1'b1;
                        end
                    end
                end else if (c < U8_CONT_LO || c > U8_CONT_HI) begin
                    utf_bad = 1'b1;
                end else if ((seq_rule == RULE_E0 && c <  U8_BOUND_A0) ||
                             (seq_rule == RULE_ED && c >= U8_BOUND_A0) ||
                             (seq_rule == RULE_F0 && c <  U8_BOUND_90) ||
                             (seq_rule == RULE_F4 && c >= U8_BOUND_90)) begin
                    utf_bad = 1'b1;
                end else begin
                    seq_rule = RULE_NONE;
                    seq_left = seq_left - 1'b1;
                end
            end
            // the UTF-8 view skips high bytes but they still break a pending CR
            if (c[7]) begin
                high_seen = 1'b1;
                if (u_tally.cr_pending) begin
                    u_tally.end_flags[LE_LONE_CR] = 1'b1;
                    u_tally.cr_pending = 1'b0;
                end
            end else begin
                low_seen = 1'b1;
                u_tally  = tally_char(u_tally, c[6:0]);
            end
            r_tally = tally_char(r_tally, c[6:0]);
        end else begin
            overran = 1'b1;
        end

        if (last) begin
            if (utf_bad)
                utf = 1'b0;
            else if (seq_left != 2'd0)
                utf = (taken == SAMPLE_MAX) && cont;
            else
                utf = multibyte;
            s = utf ? u_tally : r_tally;
            rep = '0;
            rep.is_utf8 = utf;
            rep.length  = taken;
            if (!s.binary_seen) begin
                rep.is_text   = 1'b1;
                rep.line_ends = s.end_flags | {2'b00, s.cr_pending};
                rep.high_bits = utf ? HB_UTF8 : !high_seen ? HB_CLEAR :
                                low_seen ? HB_MIXED : HB_SET;
                rep.lines     = s.lines;
                rep.has_tab   = s.tab_seen;
            end
            expected_reports.push_back(rep);
            samples_done++;
            if (utf) utf_samples++;
            if (s.binary_seen) binary_samples++;
            if (overran) overrun_samples++;
            clear_sample_state();
        end
    endtask

    // ---------------- sample construction ----------------
    task commit_sample(input logic cont);
        stream_byte_t it;
        int i;
        for (i = 0; i < sample_buf.size(); i++) begin
            it.data = sample_buf[i];
            it.last = (i == sample_buf.size() - 1);
            it.cont = it.last ? cont : 1'($urandom_range(0, 1));
            byte_feed.push_back(it);
        end
        sample_buf.delete();
    endtask

    task put_codepoint(input int unsigned cp);
        if (cp < 'h80) begin
            sample_buf.push_back(cp[7:0]);
        end else if (cp < 'h800) begin
            sample_buf.push_back({3'b110, cp[10:6]});
            sample_buf.push_back({2'b10, cp[5:0]});
        end else if (cp < 'h10000) begin
            sample_buf.push_back({4'b1110, cp[15:12]});
            sample_buf.push_back({2'b10, cp[11:6]});
            sample_buf.push_back({2'b10, cp[5:0]});
        end else begin
            sample_buf.push_back({5'b11110, cp[20:18]});
            sample_buf.push_back({2'b10, cp[17:12]});
            sample_buf.push_back({2'b10, cp[11:6]});
            sample_buf.push_back({2'b10, cp[5:0]});
        end
    endtask

    // ranges chosen so every lead byte with a second-byte bound gets hit
    function automatic int unsigned random_codepoint();
        case ($urandom_range(0, 9))
            0: return $urandom_range('h80, 'h7FF);
            1: return $urandom_range('h800, 'hFFF);
            2: return $urandom_range('h1000, 'hCFFF);
            3: return $urandom_range('hD000, 'hD7FF);
            4: return $urandom_range('hE000, 'hFFFF);
            5: return $urandom_range('h10000, 'h3FFFF);
            6: return $urandom_range('h40000, 'hFFFFF);
            7: return $urandom_range('h100000, 'h10FFFF);
            8: begin
                case ($urandom_range(0, 7))
                    0: return 'h80;
                    1: return 'h7FF;
                    2: return 'h800;
                    3: return 'hD7FF;
                    4: return 'hE000;
                    5: return 'hFFFF;
                    6: return 'h10000;
                    default: return 'h10FFFF;
                endcase
            end
            default: return $urandom_range('h20, 'h7E);
        endcase
    endfunction

    task put_text_char;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            sample_buf.push_back({1'b0, CH_CR});
        end else if (r < 10) begin
            sample_buf.push_back({1'b0, CH_LF});
        end else if (r < 14) begin
            sample_buf.push_back({1'b0, CH_CR});
            sample_buf.push_back({1'b0, CH_LF});
        end else if (r < 17) begin
            sample_buf.push_back({1'b0, CH_TAB});
        end else if (r == 17) begin
            r = $urandom_range(0, 32);
            sample_buf.push_back(r == 32 ? {1'b0, CH_DEL} : 8'(r));
        end else begin
            sample_buf.push_back(8'($urandom_range('h20, 'h7E)));
        end
    endtask

    task put_defect;
        case ($urandom_range(0, 8))
            0: sample_buf.push_back(8'($urandom_range('h80, 'hBF)));  // stray continuation
            1: begin                                                    // overlong two-byte
                sample_buf.push_back(8'($urandom_range('hC0, 'hC1)));
                sample_buf.push_back(8'($urandom_range('h80, 'hBF)));
            end
            2: sample_buf.push_back(8'($urandom_range('hF5, 'hFF)));
            3: begin                                                    // surrogate
                sample_buf.push_back(U8_LEAD_ED);
                sample_buf.push_back(8'($urandom_range('hA0, 'hBF)));
                sample_buf.push_back(8'h80);
            end
            4: begin                                                    // overlong three-byte
                sample_buf.push_back(U8_LEAD3);
                sample_buf.push_back(8'($urandom_range('h80, 'h9F)));
                sample_buf.push_back(8'h80);
            end
            5: begin                                                    // overlong four-byte
                sample_buf.push_back(U8_LEAD4);
                sample_buf.push_back(8'($urandom_range('h80, 'h8F)));
                sample_buf.push_back(8'h80);
                sample_buf.push_back(8'h80);
            end
            6: begin                                                    // above U+10FFFF
                sample_buf.push_back(U8_LEAD_HI);
                sample_buf.push_back(8'($urandom_range('h90, 'hBF)));
                sample_buf.push_back(8'h80);
                sample_buf.push_back(8'h80);
            end
            7: begin                                                    // lead then plain char
                sample_buf.push_back(8'($urandom_range('hC2, 'hF4)));
                sample_buf.push_back(8'h41);
            end
            default: begin
                sample_buf.push_back(8'hC3);
                sample_buf.push_back(8'hC3);
            end
        endcase
    endtask

    task build_random_sample;
        int len, kind, i, flaw_at;
        len     = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 40);
        kind    = $urandom_range(0, 19);
        flaw_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
        for (i = 0; i < len; i++) begin
            if (kind < 8) begin
                put_text_char();
            end else if (kind < 14) begin
                if (i == flaw_at)
                    put_defect();
                else if ($urandom_range(0, 2) == 0)
                    put_codepoint(random_codepoint());
                else
                    put_text_char();
            end else if (kind < 16) begin
                sample_buf.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 18) begin
                if ($urandom_range(0, 3) == 0)
                    sample_buf.push_back(8'($urandom_range('hA0, 'hFE)));
                else
                    put_text_char();
            end else begin
                if ($urandom_range(0, 3) == 0)
                    sample_buf.push_back(8'($urandom_range('h80, 'hFF)));
                else
                    sample_buf.push_back(8'($urandom_range('hA0, 'hFE)));
            end
        end
        // short sample ending inside a sequence
        if (kind >= 8 && kind < 14 && $urandom_range(0, 5) == 0) begin
            put_codepoint($urandom_range('h80, 'h10FFFF));
            void'(sample_buf.pop_back());
        end
        commit_sample(1'($urandom_range(0, 1)));
    endtask

    // Samples that reach the size limit with a sequence cut at the limit and
    // its tail falling past it: variant 0 with more file, variant 1 without.
    task build_full_sample(input int variant);
        int n, k;
        int unsigned cp;
        while (sample_buf.size() < SAMPLE_MAX - 16) begin
            if ($urandom_range(0, 1) == 0)
                put_codepoint(random_codepoint());
            else
                put_text_char();
        end
        n  = $urandom_range(2, 4);
        cp = (n == 2) ? $urandom_range('h80, 'h7FF) :
             (n == 3) ? $urandom_range('h800, 'hD7FF) :
                        $urandom_range('h10000, 'h10FFFF);
        k  = $urandom_range(1, n - 1);
        while (sample_buf.size() < SAMPLE_MAX - k)
            sample_buf.push_back(8'($urandom_range('h20, 'h7E)));
        put_codepoint(cp);
        commit_sample(variant == 0);
    endtask

    // ---------------- driver ----------------
    int           burst_left = 0;
    int           gap_left   = 0;
    stream_byte_t next_byte;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            s_axis_tuser  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                classify_byte(s_axis_tdata, s_axis_tlast, s_axis_tuser);
                bytes_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (byte_feed.size() > 0) begin
                    next_byte = byte_feed.pop_front();
                    s_axis_tdata  <= next_byte.data;
                    s_axis_tlast  <= next_byte.last;
                    s_axis_tuser  <= next_byte.cont;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 :
                                     ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) :
                                                                   $urandom_range(1, 6);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    logic [15:0] rx_cycle = '0;

    task check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("[%0t] report %0d %s: expected %0d, got %0d",
                     $time, reports_seen, name, want, got);
            mismatches++;
        end
    endtask

    task check_report(input logic [31:0] got);
        report_t want;
        reports_seen++;
        if (expected_reports.size() == 0) begin
            $display("[%0t] unexpected report: expected none, got 0x%08h", $time, got);
            mismatches++;
        end else begin
            want = expected_reports.pop_front();
            check_field("is_text", want.is_text, got[0]);
            check_field("is_utf8", want.is_utf8, got[1]);
            check_field("line_end_kind", want.line_ends, got[4:2]);
            check_field("high_bit_kind", want.high_bits, got[6:5]);
            check_field("line_count", want.lines, got[16:7]);
            check_field("sample_length", want.length, got[26:17]);
            check_field("has_tab", want.has_tab, got[27]);
            check_field("padding", 0, got[31:28]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_cycle      <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_report(m_axis_tdata);
            rx_cycle <= rx_cycle + 1'b1;
            // stall pattern changes character with rx_cycle[9:7]
            case (rx_cycle[9:7])
                3'd2:    m_axis_tready <= rx_cycle[0];
                3'd3:    m_axis_tready <= ($urandom_range(0, 3) != 0);
                3'd4:    m_axis_tready <= (rx_cycle[5:0] >= 6'd40);
                3'd5:    m_axis_tready <= ($urandom_range(0, 3) == 0);
                3'd6:    m_axis_tready <= (rx_cycle[3:0] != 4'd0);
                3'd7:    m_axis_tready <= ($urandom_range(0, 1) == 0);
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial begin
        int random_bytes, full_done, mark;
        clear_sample_state();

        // lowest byte alone: binary
        sample_buf.push_back(8'h00);
        commit_sample(1'b0);
        // highest byte alone: invalid UTF-8, high bit set
        sample_buf.push_back(8'hFF);
        commit_sample(1'b1);
        // lone CR, lone LF, CR LF pair and a tab
        sample_buf.push_back({1'b0, CH_CR});
        sample_buf.push_back(8'h41);
        sample_buf.push_back({1'b0, CH_LF});
        sample_buf.push_back({1'b0, CH_CR});
        sample_buf.push_back({1'b0, CH_LF});
        sample_buf.push_back({1'b0, CH_TAB});
        commit_sample(1'b0);
        // bounded second bytes at their legal edges
        put_codepoint('h80);
        put_codepoint('h800);
        put_codepoint('hD7FF);
        put_codepoint('h10FFFF);
        commit_sample(1'b0);
        // short sample cut inside a sequence, file goes on
        sample_buf.push_back(8'hE2);
        sample_buf.push_back(8'h82);
        commit_sample(1'b1);
        // DEL alone is binary
        sample_buf.push_back({1'b0, CH_DEL});
        commit_sample(1'b1);

        random_bytes = 0;
        full_done    = 0;
        while (random_bytes < RANDOM_BYTES) begin
            mark = byte_feed.size();
            build_random_sample();
            random_bytes += byte_feed.size() - mark;
            if (full_done < FULL_SAMPLES && $urandom_range(0, 29) == 0) begin
                build_full_sample(full_done);
                full_done++;
            end
        end
        while (full_done < FULL_SAMPLES) begin
            build_full_sample(full_done);
            full_done++;
        end
        total_bytes = byte_feed.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (bytes_accepted == total_bytes);
        wait (expected_reports.size() == 0);
        repeat (10) @(posedge i_clk);

        $display("Streamed %0d bytes as %0d samples, %0d of them reaching past the size limit.",
                 total_bytes, samples_done, overrun_samples);
        $display("Reports checked: %0d (%0d UTF-8, %0d binary).",
                 reports_seen, utf_samples, binary_samples);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("** text_sample_classifier: PASSED **");
        end else begin
            $display("** text_sample_classifier: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Run timed out with %0d of %0d bytes accepted and %0d reports outstanding.",
                 bytes_accepted, total_bytes, expected_reports.size());
        $display("** text_sample_classifier: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
src/tsc_pkg.sv
src/tsc_utf8_check.sv
src/tsc_text_stats.sv
src/text_sample_classifier.sv
dv/testbench.sv
